// ----- design/apd_pkg.sv -----
// shared constants and tables for the arc pose block
package apd_pkg;

  // angles in 16-bit fractions of a turn
  localparam logic [15:0] TURN_QUARTER = 16'h4000;
  localparam logic [15:0] TURN_HALF    = 16'h8000;
  localparam logic [15:0] TURN_OCTANT  = 16'h2000;

  // round(2^32 / (2*pi))
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

  // cordic datapath: x, y in q2.30 and residual angle in 2^-32 turn, with headroom
  localparam int CORDIC_XW = 34;
  localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic signed [CORDIC_XW-1:0] ATAN_TURNS [0:31] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81,
    34'sd41,        34'sd20,        34'sd10,        34'sd5,
    34'sd3,         34'sd1,         34'sd1,         34'sd0
  };

  // divider: numerator bits after the 2^16 prescale, divisor is |radius|
  localparam int DIV_NW = 47;
  localparam int DIV_DW = 32;
  localparam int DIV_QW = 16;

  // register map
  localparam logic [7:0] CFG_IDX_RADIUS     = 8'd0;
  localparam logic [7:0] CFG_IDX_START_DIST = 8'd1;
  localparam logic [31:0] RADIUS_RST        = 32'h0001_0000;
  localparam logic [31:0] START_DIST_RST    = 32'h0000_0000;

endpackage

// ----- design/apd_div.sv -----
// pipelined restoring divider, one quotient bit per stage, keeps the low quotient bits
module apd_div #(
  parameter int NW     = 47,
  parameter int DW     = 32,
  parameter int QW     = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     in_num,
  input  logic [DW-1:0]     in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QW-1:0]     out_quot,
  output logic [SIDE_W-1:0] out_side
);

  logic [DW:0]       rem_r  [0:NW-1];
  logic [NW-1:0]     num_r  [0:NW-1];
  logic [DW-1:0]     den_r  [0:NW-1];
  logic [QW-1:0]     quo_r  [0:NW-1];
  logic [SIDE_W-1:0] side_r [0:NW-1];
  logic              v_r    [0:NW-1];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0]       rem_in;
    logic [NW-1:0]     num_in;
    logic [DW-1:0]     den_in;
    logic [QW-1:0]     quo_in;
    logic [SIDE_W-1:0] side_in;
    logic              v_in;
    logic [DW:0]       rsh;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign num_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign num_in  = num_r[i-1];
      assign den_in  = den_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign side_in = side_r[i-1];
      assign v_in    = v_r[i-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign rsh = {rem_in[DW-1:0], num_in[NW-1-i]};
    assign ge  = (rsh >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? (rsh - {1'b0, den_in}) : rsh;
        num_r[i]  <= num_in;
        den_r[i]  <= den_in;
        quo_r[i]  <= {quo_in[QW-2:0], ge};
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quot  = quo_r[NW-1];
  assign out_side  = side_r[NW-1];

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NW-1] && (den_r[NW-1] != '0)) |-> (rem_r[NW-1] < {1'b0, den_r[NW-1]}))
    else $error("divider remainder not below divisor");

endmodule

// ----- design/apd_cordic.sv -----
// pipelined rotation-mode cordic giving cos and sin of a 16-bit turn angle
module apd_cordic #(
  parameter int STEPS     = 16,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [15:0]                 in_angle,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+3:0] out_cos,
  output logic signed [FRAC_BITS+3:0] out_sin,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int XW = apd_pkg::CORDIC_XW;
  localparam int CW = FRAC_BITS + 4;
  localparam int RS = 30 - FRAC_BITS;

  logic signed [XW-1:0] x_r    [0:STEPS];
  logic signed [XW-1:0] y_r    [0:STEPS];
  logic signed [XW-1:0] z_r    [0:STEPS];
  logic [1:0]           quad_r [0:STEPS];
  logic [SIDE_W-1:0]    side_r [0:STEPS];
  logic                 v_r    [0:STEPS];

  // quadrant reduction to [-1/8, 1/8) turn
  logic [15:0]          ang_oct;
  logic [1:0]           quad;
  logic [15:0]          rem16;
  logic signed [XW-1:0] z0;

  assign ang_oct = in_angle + apd_pkg::TURN_OCTANT;
  assign quad    = ang_oct[15:14];
  assign rem16   = in_angle - {quad, 14'b0};
  assign z0      = {{(XW-32){rem16[15]}}, rem16, 16'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= apd_pkg::CORDIC_GAIN_Q30;
      y_r[0]    <= '0;
      z_r[0]    <= z0;
      quad_r[0] <= quad;
      side_r[0] <= in_side;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][XW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - apd_pkg::ATAN_TURNS[i];
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + apd_pkg::ATAN_TURNS[i];
        end
        quad_r[i+1] <= quad_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  // round to frac_bits, then put the quadrant back
  logic signed [XW-1:0] x_rnd, y_rnd;
  logic signed [CW-1:0] cx, sy;
  logic signed [CW-1:0] cos_nxt, sin_nxt;
  logic signed [CW-1:0] cos_r, sin_r;
  logic [SIDE_W-1:0]    side_o_r;
  logic                 v_o_r;

  assign x_rnd = x_r[STEPS] + (XW'(1) <<< (RS - 1));
  assign y_rnd = y_r[STEPS] + (XW'(1) <<< (RS - 1));
  assign cx    = x_rnd[XW-1:RS];
  assign sy    = y_rnd[XW-1:RS];

  always_comb begin
    case (quad_r[STEPS])
      2'd0: begin
        cos_nxt = cx;
        sin_nxt = sy;
      end
      2'd1: begin
        cos_nxt = -sy;
        sin_nxt = cx;
      end
      2'd2: begin
        cos_nxt = -cx;
        sin_nxt = -sy;
      end
      default: begin
        cos_nxt = sy;
        sin_nxt = -cx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o_r <= 1'b0;
    end else if (en) begin
      v_o_r <= v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r    <= cos_nxt;
      sin_r    <= sin_nxt;
      side_o_r <= side_r[STEPS];
    end
  end

  assign out_valid = v_o_r;
  assign out_cos   = cos_r;
  assign out_sin   = sin_r;
  assign out_side  = side_o_r;

endmodule

// ----- design/arc_pose_at_distance.sv -----
// top level: pose and centre on a circular arc at a given path distance
//
//  channel | dir | handshake           | content
//  in_     | in  | in_tvalid/in_tready | start_x, start_y, start_heading, path_distance
//  out_    | out | out_tvalid/tready   | pose_x, pose_y, pose_heading, centre_x, centre_y;
//          |     |                     | tuser = zero_radius
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index selects radius or start distance
//
// one item per cycle while the pipeline advances; most of the pipeline depth is the
// 47-stage divider for the swept angle and the cordic pipeline behind it
// the whole pipeline advances together whenever the output register is empty or taken
// stalling out_tready freezes every stage, nothing is dropped or repeated
// reset clears all valid bits and loads the register defaults, payload is not reset
module arc_pose_at_distance #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // start_x, start_y, start_heading, path_distance
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // pose_x, pose_y, pose_heading, centre_x, centre_y
  output logic [0:0]   out_tuser,  // zero_radius
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int CW = FRAC_BITS + 4;       // cos/sin width
  localparam int PW = 33 + CW;             // |r| times cos/sin
  localparam int TW = PW - FRAC_BITS;      // rounded offset term

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [15:0] hd;
    logic [15:0] beta;
    logic [31:0] mag;
    logic        pos;
    logic        zero;
    logic        neg;
  } front_t;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [15:0] hd;
    logic [31:0] mag;
    logic        zero;
  } bside_t;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [15:0] hd;
    logic [15:0] head;
    logic        zero;
  } tail_t;

  // ---------------------------------------------------------------- config
  logic [31:0] radius_r, start_dist_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= apd_pkg::RADIUS_RST;
      start_dist_r <= apd_pkg::START_DIST_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        apd_pkg::CFG_IDX_RADIUS:     radius_r     <= cfg_data;
        apd_pkg::CFG_IDX_START_DIST: start_dist_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: output register empty or being taken
  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // ---------------------------------------------------------------- s1: unpack
  // distance offset, |radius|, turn direction and beta = heading -/+ quarter turn
  logic [31:0]        in_sx, in_sy, in_dist;
  logic [15:0]        in_hd;
  logic signed [32:0] delta;
  logic [32:0]        delta_abs;
  front_t             s1_nxt, s1_r;
  logic [31:0]        s1_absd_r;
  logic               s1_v_r;

  assign in_sx   = in_tdata[31:0];
  assign in_sy   = in_tdata[63:32];
  assign in_hd   = in_tdata[79:64];
  assign in_dist = in_tdata[111:80];

  assign delta     = {in_dist[31], in_dist} - {start_dist_r[31], start_dist_r};
  assign delta_abs = delta[32] ? -delta : delta;

  always_comb begin
    s1_nxt.sx   = in_sx;
    s1_nxt.sy   = in_sy;
    s1_nxt.hd   = in_hd;
    s1_nxt.pos  = !radius_r[31];
    // negative full scale gives 2^31, still exact in 32 unsigned bits
    s1_nxt.mag  = radius_r[31] ? -radius_r : radius_r;
    s1_nxt.zero = (radius_r == '0);
    s1_nxt.neg  = delta[32];
    s1_nxt.beta = radius_r[31] ? (in_hd + apd_pkg::TURN_QUARTER)
                               : (in_hd - apd_pkg::TURN_QUARTER);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r      <= s1_nxt;
      s1_absd_r <= delta_abs[31:0];
    end
  end

  // ---------------------------------------------------------------- s2: |d-d0| / (2 pi)
  logic [61:0] s2_prod_r;
  front_t      s2_r;
  logic        s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_prod_r <= 62'(s1_absd_r) * 62'(apd_pkg::INV_TWO_PI_Q32);
      s2_r      <= s1_r;
    end
  end

  // ---------------------------------------------------------------- s3: round-half bias
  // adding |r|*2^15 then dropping 16 bits leaves a plain floor divide by |r|
  logic [62:0]                 s3_sum;
  logic [apd_pkg::DIV_NW-1:0]  s3_num_r;
  front_t                      s3_r;
  logic                        s3_v_r;

  assign s3_sum = {1'b0, s2_prod_r} + {16'b0, s2_r.mag, 15'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_num_r <= s3_sum[62:16];
      s3_r     <= s2_r;
    end
  end

  // ---------------------------------------------------------------- divider
  logic                       div_v;
  logic [apd_pkg::DIV_QW-1:0] div_q;
  front_t                     div_side;

  apd_div #(
    .NW     (apd_pkg::DIV_NW),
    .DW     (apd_pkg::DIV_DW),
    .QW     (apd_pkg::DIV_QW),
    .SIDE_W ($bits(front_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_num    (s3_num_r),
    .in_den    (s3_r.mag),
    .in_side   (s3_r),
    .out_valid (div_v),
    .out_quot  (div_q),
    .out_side  (div_side)
  );

  // ---------------------------------------------------------------- s4: arc angles
  logic [15:0] phi, alpha, head;
  logic [15:0] s4_alpha_r, s4_beta_r, s4_head_r;
  bside_t      s4_side_r;
  logic        s4_v_r;

  assign phi   = div_side.neg ? -div_q : div_q;
  assign alpha = div_side.pos ? (div_side.beta + apd_pkg::TURN_HALF - phi)
                              : (div_side.beta - apd_pkg::TURN_HALF + phi);
  assign head  = div_side.pos ? (alpha - apd_pkg::TURN_QUARTER)
                              : (alpha + apd_pkg::TURN_QUARTER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_alpha_r     <= alpha;
      s4_beta_r      <= div_side.beta;
      s4_head_r      <= head;
      s4_side_r.sx   <= div_side.sx;
      s4_side_r.sy   <= div_side.sy;
      s4_side_r.hd   <= div_side.hd;
      s4_side_r.mag  <= div_side.mag;
      s4_side_r.zero <= div_side.zero;
    end
  end

  // ---------------------------------------------------------------- cos/sin of beta and alpha
  logic                 b_v, a_v;
  logic signed [CW-1:0] b_cos, b_sin, a_cos, a_sin;
  bside_t               b_side;
  logic [15:0]          a_head;

  apd_cordic #(
    .STEPS     (CORDIC_STEPS),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    ($bits(bside_t))
  ) u_cordic_beta (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_v_r),
    .in_angle  (s4_beta_r),
    .in_side   (s4_side_r),
    .out_valid (b_v),
    .out_cos   (b_cos),
    .out_sin   (b_sin),
    .out_side  (b_side)
  );

  apd_cordic #(
    .STEPS     (CORDIC_STEPS),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (16)
  ) u_cordic_alpha (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_v_r),
    .in_angle  (s4_alpha_r),
    .in_side   (s4_head_r),
    .out_valid (a_v),
    .out_cos   (a_cos),
    .out_sin   (a_sin),
    .out_side  (a_head)
  );

  // ---------------------------------------------------------------- s5: |r| * cos/sin
  logic signed [PW-1:0] s5_pbx_r, s5_pby_r, s5_pax_r, s5_pay_r;
  logic signed [32:0]   mag_s;
  tail_t                s5_r;
  logic                 s5_v_r;

  assign mag_s = {1'b0, b_side.mag};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_pbx_r  <= mag_s * b_cos;
      s5_pby_r  <= mag_s * b_sin;
      s5_pax_r  <= mag_s * a_cos;
      s5_pay_r  <= mag_s * a_sin;
      s5_r.sx   <= b_side.sx;
      s5_r.sy   <= b_side.sy;
      s5_r.hd   <= b_side.hd;
      s5_r.head <= a_head;
      s5_r.zero <= b_side.zero;
    end
  end

  // ---------------------------------------------------------------- s6: round offset terms
  logic signed [PW-1:0] rnd_bx, rnd_by, rnd_ax, rnd_ay;
  logic signed [TW-1:0] s6_tbx_r, s6_tby_r, s6_tax_r, s6_tay_r;
  tail_t                s6_r;
  logic                 s6_v_r;

  assign rnd_bx = s5_pbx_r + (PW'(1) <<< (FRAC_BITS - 1));
  assign rnd_by = s5_pby_r + (PW'(1) <<< (FRAC_BITS - 1));
  assign rnd_ax = s5_pax_r + (PW'(1) <<< (FRAC_BITS - 1));
  assign rnd_ay = s5_pay_r + (PW'(1) <<< (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tbx_r <= rnd_bx[PW-1:FRAC_BITS];
      s6_tby_r <= rnd_by[PW-1:FRAC_BITS];
      s6_tax_r <= rnd_ax[PW-1:FRAC_BITS];
      s6_tay_r <= rnd_ay[PW-1:FRAC_BITS];
      s6_r     <= s5_r;
    end
  end

  // ---------------------------------------------------------------- s7: centre, unsaturated
  logic signed [TW:0]   s7_cx_r, s7_cy_r;
  logic signed [TW-1:0] s7_tax_r, s7_tay_r;
  tail_t                s7_r;
  logic                 s7_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_cx_r  <= {{(TW-31){s6_r.sx[31]}}, s6_r.sx} + {s6_tbx_r[TW-1], s6_tbx_r};
      s7_cy_r  <= {{(TW-31){s6_r.sy[31]}}, s6_r.sy} + {s6_tby_r[TW-1], s6_tby_r};
      s7_tax_r <= s6_tax_r;
      s7_tay_r <= s6_tay_r;
      s7_r     <= s6_r;
    end
  end

  // ---------------------------------------------------------------- s8: pose, saturate, output
  function automatic logic [31:0] sat32(input logic signed [TW+1:0] v);
    logic [31:0] res;
    if (v > (TW+2)'(64'sd2147483647)) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -(TW+2)'(64'sd2147483648)) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  logic signed [TW+1:0] px, py, cxw, cyw;
  logic [143:0]         out_data_nxt;
  logic [143:0]         out_data_r;
  logic                 out_zero_r;
  logic                 out_v_r;

  assign cxw = {s7_cx_r[TW], s7_cx_r};
  assign cyw = {s7_cy_r[TW], s7_cy_r};
  assign px  = cxw + {{2{s7_tax_r[TW-1]}}, s7_tax_r};
  assign py  = cyw + {{2{s7_tay_r[TW-1]}}, s7_tay_r};

  always_comb begin
    if (s7_r.zero) begin
      // zero radius: start pose goes straight through
      out_data_nxt = {s7_r.sy, s7_r.sx, s7_r.hd, s7_r.sy, s7_r.sx};
    end else begin
      out_data_nxt = {sat32(cyw), sat32(cxw), s7_r.head, sat32(py), sat32(px)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_zero_r <= s7_r.zero;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_zero_r;

  // ---------------------------------------------------------------- checks
  a_cordic_align: assert property (@(posedge clk) disable iff (!rst_n)
    a_v == b_v)
    else $error("cordic lanes out of step");

  a_zero_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata[31:0] == out_tdata[111:80]) && (out_tdata[63:32] == out_tdata[143:112]))
    else $error("zero radius item does not pass start position");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(div_v) && $stable(b_v) && $stable(s7_v_r)))
    else $error("pipeline moved while stalled");

endmodule

// ----- dv/arc_pose_at_distance_tb.sv -----
// testbench for the arc pose block: scoreboard with a bit-exact predictor, random traffic
module arc_pose_at_distance_tb;

  localparam int STEPS = 16;
  localparam int FBITS = 16;
  localparam int LATENCY = STEPS + 57;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] hdg;
    logic [31:0] ctr_x;
    logic [31:0] ctr_y;
    logic        zero_r;
  } arc_pose_t;

  // arithmetic shift right that floors, on 64-bit values
  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // cos and sin of a turn angle via the cordic rotation, Q1.FBITS
  function automatic void turn_to_unit(logic [15:0] ang, output longint c, output longint s);
    logic [15:0] rem16;
    logic [1:0] quad;
    longint x, y, z, xs, ys, cx, sy;
    quad = 2'((17'(ang) + 17'h2000) >> 14);
    rem16 = ang - {quad, 14'd0};
    x = 652032874;
    y = 0;
    z = longint'($signed(rem16)) * 65536;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(apd_pkg::ATAN_TURNS[i]);
      end else begin
        x += ys; y -= xs; z += longint'(apd_pkg::ATAN_TURNS[i]);
      end
    end
    cx = floor_shift(x + (64'sd1 << (29 - FBITS)), 30 - FBITS);
    sy = floor_shift(y + (64'sd1 << (29 - FBITS)), 30 - FBITS);
    case (quad)
      2'd0: begin c = cx; s = sy; end
      2'd1: begin c = -sy; s = cx; end
      2'd2: begin c = -cx; s = -sy; end
      default: begin c = sy; s = -cx; end
    endcase
  endfunction

  function automatic longint radius_term(longint mag, longint u);
    return floor_shift(mag * u + (64'sd1 << (FBITS - 1)), FBITS);
  endfunction

  class arc_scoreboard;
    logic [31:0] radius = apd_pkg::RADIUS_RST;
    logic [31:0] start_dist = apd_pkg::START_DIST_RST;
    arc_pose_t pending[$];
    int errors = 0;

    function void write_reg(logic [7:0] idx, logic [31:0] val);
      if (idx == apd_pkg::CFG_IDX_RADIUS) radius = val;
      else if (idx == apd_pkg::CFG_IDX_START_DIST) start_dist = val;
    endfunction

    function void note_query(logic [111:0] d);
      longint sx, sy, qdist, r, mag, delta, cb, sb, ca, sa, cx, cy;
      logic [15:0] hd, beta, phi, alpha;
      logic [127:0] num, den, q;
      arc_pose_t p;
      sx = longint'($signed(d[31:0]));
      sy = longint'($signed(d[63:32]));
      hd = d[79:64];
      qdist = longint'($signed(d[111:80]));
      r = longint'($signed(radius));
      if (r == 0) begin
        p = '{d[31:0], d[63:32], hd, d[31:0], d[63:32], 1'b1};
      end else begin
        mag = r > 0 ? r : -r;
        beta = r > 0 ? hd - apd_pkg::TURN_QUARTER : hd + apd_pkg::TURN_QUARTER;
        delta = qdist - longint'($signed(start_dist));
        num = 128'(delta < 0 ? -delta : delta) * 128'(apd_pkg::INV_TWO_PI_Q32);
        den = 128'(mag) << 16;
        q = (num + den / 2) / den;
        phi = q[15:0];
        if (delta < 0) phi = 16'd0 - phi;
        alpha = r > 0 ? beta + apd_pkg::TURN_HALF - phi : beta - apd_pkg::TURN_HALF + phi;
        turn_to_unit(beta, cb, sb);
        turn_to_unit(alpha, ca, sa);
        cx = sx + radius_term(mag, cb);
        cy = sy + radius_term(mag, sb);
        p.pos_x = clamp32(cx + radius_term(mag, ca));
        p.pos_y = clamp32(cy + radius_term(mag, sa));
        p.hdg = r > 0 ? alpha - apd_pkg::TURN_QUARTER : alpha + apd_pkg::TURN_QUARTER;
        p.ctr_x = clamp32(cx);
        p.ctr_y = clamp32(cy);
        p.zero_r = 1'b0;
      end
      pending.push_back(p);
    endfunction

    function void check_result(logic [143:0] d, logic u);
      arc_pose_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.pos_x) begin
        $error("pose_x exp %h got %h", e.pos_x, d[31:0]); errors++;
      end
      if (d[63:32] !== e.pos_y) begin
        $error("pose_y exp %h got %h", e.pos_y, d[63:32]); errors++;
      end
      if (d[79:64] !== e.hdg) begin
        $error("pose_heading exp %h got %h", e.hdg, d[79:64]); errors++;
      end
      if (d[111:80] !== e.ctr_x) begin
        $error("centre_x exp %h got %h", e.ctr_x, d[111:80]); errors++;
      end
      if (d[143:112] !== e.ctr_y) begin
        $error("centre_y exp %h got %h", e.ctr_y, d[143:112]); errors++;
      end
      if (u !== e.zero_r) begin
        $error("zero_radius exp %b got %b", e.zero_r, u); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [111:0] in_tdata = '0;   // start_x, start_y, start_heading, path_distance
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [143:0] out_tdata;       // pose_x, pose_y, pose_heading, centre_x, centre_y
  logic [0:0] out_tuser;         // zero_radius
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  arc_scoreboard sb = new();
  bit sending_done = 0;

  arc_pose_at_distance u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stall per item, and a stretch with no stall
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = sending_done ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15));
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
      sb.check_result(out_tdata, out_tuser[0]);
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one query item, with a random hold-off unless burst mode; valid stays up afterwards
  task automatic send_query(logic [31:0] sx, logic [31:0] sy, logic [15:0] hd,
                            logic [31:0] qdist, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {qdist, hd, sy, sx};
    @(posedge clk iff in_tready);
    sb.note_query({qdist, hd, sy, sx});
  endtask

  // stop sending and wait until every expected result has come
  task automatic wait_empty();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // wait for the pipeline to drain before touching registers
  task automatic drain();
    wait_empty();
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000 | $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  logic [31:0] radius_set[] = '{32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0010_0000,
                                32'hFFC0_0000};
  logic [31:0] dist_set[] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000};

  initial begin
    logic [31:0] rnd;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes at reset settings, then ignored register indices
    send_query(32'h0, 32'h0, 16'h0, 32'h0, 0);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF, 0);
    send_query(32'h8000_0000, 32'h8000_0000, 16'h8000, 32'h8000_0000, 0);
    send_query(32'h0001_0000, 32'hFFFF_0000, 16'h2000, 32'h0001_921F, 0);
    send_query(32'h0, 32'h0, 16'h1FFF, 32'hFFFE_6DE1, 1);
    send_query(32'h0, 32'h0, 16'h6000, 32'h0000_8000, 1);
    drain();
    write_reg(8'd2, 32'h0);
    write_reg(8'hFF, 32'h1234_5678);
    send_query(32'h0, 32'h0, 16'h0, 32'h0001_0000, 0);

    // sweep the register settings, random queries under each
    foreach (radius_set[i]) begin
      drain();
      write_reg(apd_pkg::CFG_IDX_RADIUS, radius_set[i]);
      write_reg(apd_pkg::CFG_IDX_START_DIST, dist_set[i % dist_set.size()]);
      for (int k = 0; k < 60; k++) begin
        rnd = $urandom();
        send_query(rand_pos(), rand_pos(), rnd[15:0], rand_pos(), (i % 3) == 1);
        // sender holds off once until everything has come back
        if (i == 2 && k == 30) wait_empty();
      end
    end

    drain();
    sending_done = 1;
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
